// File: rtl/vrrq_pkg.sv
// Package for the variable-length record ring queue.
// Holds shared constants, status codes and the front-to-back command type.
package vrrq_pkg;
	localparam int RingBytes = 4096;
	localparam int MaxMsgLen = 64;
	localparam int HdrBytes = 12;
	localparam int PosW = 17;

	typedef enum logic [2:0] {
		ST_ENQ_OK = 3'd0,
		ST_ENQ_OK_EMPTY = 3'd1,
		ST_ENQ_FULL = 3'd2,
		ST_DEQ_OK = 3'd3,
		ST_DEQ_EMPTY = 3'd4,
		ST_DEQ_TOO_BIG = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CMD_ENQ_OPEN = 2'd0,
		CMD_ENQ_BYTE = 2'd1,
		CMD_DEQ = 2'd2
	} cmd_kind_t;

	// One classified item passed from the front part to the back part.
	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] byte_value;
		logic [6:0] msg_len;
		logic [63:0] flow_id;
		logic [6:0] buf_limit;
	} cmd_t;
endpackage

// File: rtl/vrrq_if.sv
// Valid/ready channel interfaces for the record ring queue.
// Depends on nothing but plain logic types.
interface vrrq_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [7:0] byte_value;
	logic [6:0] msg_len;
	logic [63:0] flow_id;
	logic [6:0] buf_limit;
	modport source (output valid, req_type, byte_value, msg_len, flow_id, buf_limit,
		input ready);
	modport sink (input valid, req_type, byte_value, msg_len, flow_id, buf_limit,
		output ready);
endinterface

interface vrrq_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [7:0] out_byte;
	logic byte_valid;
	logic [63:0] out_flow_id;
	logic [6:0] payload_len;
	logic last;
	modport source (output valid, status, out_byte, byte_valid, out_flow_id, payload_len,
		last, input ready);
	modport sink (input valid, status, out_byte, byte_valid, out_flow_id, payload_len,
		last, output ready);
endinterface

// File: rtl/variable_record_ring_queue.sv
// Top level of the variable-length record ring queue.
// Ties the front classifier, the back executor and the size register. Uses vrrq_pkg
// and the channel interfaces in vrrq_if.sv.
//
// Channel   Dir  Handshake    Content
// in_ch     in   valid/ready  req_type, byte_value, msg_len, flow_id, buf_limit
// out_ch    out  valid/ready  status, out_byte, byte_valid, out_flow_id, payload_len, last
// cfg       in   cfg_we       cfg_wdata = ring_size
//
// An enqueue byte or a refused opening byte is handled in the idle state of the back part; an
// accepted opening byte writes the 12 header bytes and then the first payload byte, if the
// payload is not empty.
// A dequeue reads the header, then sends one payload byte a cycle unless the output stalls.
// Reset and a size write empty the queue at once; the ring holds no valid bits.
// A stalled output holds the back part; the two-entry queue then fills and stalls input.
module variable_record_ring_queue #(
	parameter int RING_BYTES = vrrq_pkg::RingBytes,
	parameter int MAX_MSG_LEN = vrrq_pkg::MaxMsgLen
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [12:0] cfg_wdata,
	vrrq_in_if.sink in_ch,
	vrrq_out_if.source out_ch
);
	logic [12:0] ring_size_q;
	logic cmd_valid, cmd_pop, busy;
	vrrq_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ring_size_q <= 13'd4096;
		else if (cfg_we) ring_size_q <= cfg_wdata;
	end

	vrrq_front u_front (
		.clk(clk), .arst_n(arst_n), .clear(cfg_we), .in_ch(in_ch),
		.cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
	);

	vrrq_back #(.RING_BYTES(RING_BYTES), .MAX_MSG_LEN(MAX_MSG_LEN)) u_back (
		.clk(clk), .arst_n(arst_n), .clear(cfg_we), .ring_size(ring_size_q),
		.cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd), .out_ch(out_ch), .busy(busy)
	);

	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("pop from empty command queue");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.status <= 3'd5) else $error("bad status code");
	a_bytes_on_deq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.byte_valid) |-> out_ch.status == vrrq_pkg::ST_DEQ_OK)
		else $error("payload byte outside dequeue");
	a_idle_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !out_ch.valid) else $error("output valid while idle");
endmodule

// File: rtl/vrrq_front.sv
// Front part: tracks message framing and classifies each input item.
// Pushes one vrrq_pkg::cmd_t per item into a two-entry queue. Uses vrrq_pkg.
module vrrq_front (
	input logic clk,
	input logic arst_n,
	input logic clear,
	vrrq_in_if.sink in_ch,
	output logic cmd_valid,
	input logic cmd_pop,
	output vrrq_pkg::cmd_t cmd
);
	vrrq_pkg::cmd_t fifo_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic [6:0] remain_q;
	vrrq_pkg::cmd_t c;
	logic push;

	assign in_ch.ready = (cnt_q != 2'd2) && !clear;
	assign push = in_ch.valid && in_ch.ready;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd = fifo_q[rd_q];

	always_comb begin
		c.byte_value = in_ch.byte_value;
		c.msg_len = in_ch.msg_len;
		c.flow_id = in_ch.flow_id;
		c.buf_limit = in_ch.buf_limit;
		if (in_ch.req_type)
			c.kind = vrrq_pkg::CMD_DEQ;
		else if (remain_q == 7'd0)
			c.kind = vrrq_pkg::CMD_ENQ_OPEN;
		else
			c.kind = vrrq_pkg::CMD_ENQ_BYTE;
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
			remain_q <= 7'd0;
		end else if (clear) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
			remain_q <= 7'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (cmd_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
			if (push && !in_ch.req_type) begin
				if (remain_q == 7'd0)
					remain_q <= (in_ch.msg_len == 7'd0) ? 7'd0 : in_ch.msg_len - 7'd1;
				else
					remain_q <= remain_q - 7'd1;
			end
		end
	end
endmodule

// File: rtl/vrrq_back.sv
// Back part: owns the byte ring memory and the ring pointers.
// Executes enqueue and dequeue commands one memory byte per cycle unless the output stalls. Uses vrrq_pkg.
module vrrq_back #(
	parameter int RING_BYTES = vrrq_pkg::RingBytes,
	parameter int MAX_MSG_LEN = vrrq_pkg::MaxMsgLen
) (
	input logic clk,
	input logic arst_n,
	input logic clear,
	input logic [12:0] ring_size,
	input logic cmd_valid,
	output logic cmd_pop,
	input vrrq_pkg::cmd_t cmd,
	vrrq_out_if.source out_ch,
	output logic busy
);
	localparam int AW = $clog2(RING_BYTES);
	localparam int PW = vrrq_pkg::PosW;
	localparam logic [PW-1:0] MinRing = PW'(vrrq_pkg::HdrBytes + MAX_MSG_LEN + 1);
	localparam logic [PW-1:0] MaxRing = PW'(RING_BYTES);
	localparam logic [PW-1:0] Hdr = PW'(vrrq_pkg::HdrBytes);

	typedef enum logic [2:0] {
		S_IDLE, S_HDR_WR, S_RD_REQ, S_RD_HDR, S_RD_PAY, S_OUT
	} state_t;

	logic [7:0] mem [RING_BYTES];
	logic [7:0] rdata_q;
	logic mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0] mem_wd;

	state_t state_q;
	logic [PW-1:0] size, rd_pos_q, wr_pos_q, fill_q, cur_q, space_left;
	logic rejected_q, was_empty_q;
	logic [3:0] idx_q;
	logic [95:0] hdr_q;
	logic [7:0] first_q;
	logic [6:0] plen_q, cnt_q, limit_q;
	logic [PW-1:0] total;
	// Tracks bytes still owed to the open message in this part.
	logic [6:0] owe_q;

	always_comb begin
		size = {4'd0, ring_size};
		if (size < MinRing) size = MinRing;
		if (size > MaxRing) size = MaxRing;
	end

	function automatic logic [PW-1:0] wrap(input logic [PW-1:0] p, input logic [PW-1:0] n,
		input logic [PW-1:0] s);
		logic [PW-1:0] t;
		t = p + n;
		return (t >= s) ? t - s : t;
	endfunction

	assign space_left = (rd_pos_q > wr_pos_q) ? rd_pos_q - wr_pos_q
		: rd_pos_q + size - wr_pos_q;
	assign total = PW'(hdr_q[31:0]);

	wire out_free = !out_ch.valid || out_ch.ready;
	wire [PW-1:0] msg_need = PW'(cmd.msg_len) + Hdr;

	always_comb begin
		cmd_pop = 1'b0;
		if (state_q == S_IDLE && cmd_valid && out_free && !clear) cmd_pop = 1'b1;
	end

	// A stalled payload byte must stay in the read register.
	assign mem_re = !(state_q == S_RD_PAY && out_ch.valid && !out_ch.ready);

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= mem[mem_ra];
	end

	assign busy = (state_q != S_IDLE) || out_ch.valid || cmd_valid;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = fill_q[AW-1:0];
		mem_wd = cmd.byte_value;
		mem_ra = cur_q[AW-1:0];
		if (state_q == S_IDLE && cmd_pop && cmd.kind == vrrq_pkg::CMD_ENQ_BYTE
			&& !rejected_q) begin
			mem_we = 1'b1;
		end else if (state_q == S_HDR_WR) begin
			mem_we = 1'b1;
			mem_wa = cur_q[AW-1:0];
			mem_wd = (idx_q == 4'd12) ? first_q : hdr_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rd_pos_q <= '0;
			wr_pos_q <= '0;
			fill_q <= '0;
			rejected_q <= 1'b0;
			was_empty_q <= 1'b0;
			out_ch.valid <= 1'b0;
		end else if (clear) begin
			state_q <= S_IDLE;
			rd_pos_q <= '0;
			wr_pos_q <= '0;
			fill_q <= '0;
			rejected_q <= 1'b0;
			was_empty_q <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						out_ch.out_byte <= 8'd0;
						out_ch.byte_valid <= 1'b0;
						out_ch.out_flow_id <= 64'd0;
						out_ch.payload_len <= 7'd0;
						out_ch.last <= 1'b1;
						unique case (cmd.kind)
							vrrq_pkg::CMD_ENQ_OPEN: begin
								was_empty_q <= rd_pos_q == wr_pos_q;
								if (cmd.msg_len > 7'(MAX_MSG_LEN) || space_left <= msg_need) begin
									rejected_q <= 1'b1;
									out_ch.status <= vrrq_pkg::ST_ENQ_FULL;
									out_ch.valid <= 1'b1;
								end else begin
									rejected_q <= 1'b0;
									hdr_q <= {cmd.flow_id, 25'd0, cmd.msg_len + 7'd12};
									first_q <= cmd.byte_value;
									plen_q <= cmd.msg_len;
									cur_q <= wr_pos_q;
									idx_q <= 4'd0;
									state_q <= S_HDR_WR;
								end
							end
							vrrq_pkg::CMD_ENQ_BYTE: begin
								if (!rejected_q) begin
									fill_q <= wrap(fill_q, PW'(1), size);
								end
								out_ch.status <= rejected_q ? vrrq_pkg::ST_ENQ_FULL
									: (was_empty_q ? vrrq_pkg::ST_ENQ_OK_EMPTY
									: vrrq_pkg::ST_ENQ_OK);
								out_ch.valid <= 1'b1;
							end
							default: begin
								if (rd_pos_q == wr_pos_q) begin
									out_ch.status <= vrrq_pkg::ST_DEQ_EMPTY;
									out_ch.valid <= 1'b1;
								end else begin
									limit_q <= cmd.buf_limit;
									cur_q <= rd_pos_q;
									idx_q <= 4'd0;
									state_q <= S_RD_REQ;
								end
							end
						endcase
					end
				end
				S_HDR_WR: begin
					// Header bytes, then the first payload byte if there is one.
					hdr_q <= {8'd0, hdr_q[95:8]};
					cur_q <= wrap(cur_q, PW'(1), size);
					idx_q <= idx_q + 4'd1;
					if ((plen_q == 7'd0 && idx_q == 4'd11) || idx_q == 4'd12) begin
						state_q <= S_IDLE;
						fill_q <= wrap(cur_q, PW'(1), size);
						if (plen_q <= 7'd1) wr_pos_q <= wrap(cur_q, PW'(1), size);
						out_ch.status <= was_empty_q ? vrrq_pkg::ST_ENQ_OK_EMPTY
							: vrrq_pkg::ST_ENQ_OK;
						out_ch.valid <= 1'b1;
					end
				end
				S_RD_REQ: begin
					cur_q <= wrap(cur_q, PW'(1), size);
					state_q <= S_RD_HDR;
				end
				S_RD_HDR: begin
					hdr_q <= {rdata_q, hdr_q[95:8]};
					idx_q <= idx_q + 4'd1;
					if (idx_q != 4'd11) cur_q <= wrap(cur_q, PW'(1), size);
					else state_q <= S_OUT;
				end
				S_OUT: begin
					// Header complete: judge length, then stream payload.
					if (hdr_q[31:0] < 32'd12 || hdr_q[31:0] - 32'd12 > 32'(MAX_MSG_LEN)
						|| hdr_q[31:0] - 32'd12 > {25'd0, limit_q}) begin
						out_ch.status <= vrrq_pkg::ST_DEQ_TOO_BIG;
						out_ch.out_flow_id <= hdr_q[95:32];
						out_ch.payload_len <= (hdr_q[31:0] >= 32'd12)
							? 7'(hdr_q[31:0] - 32'd12) : 7'd0;
						out_ch.valid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						plen_q <= 7'(hdr_q[31:0] - 32'd12);
						out_ch.out_flow_id <= hdr_q[95:32];
						rd_pos_q <= wrap(rd_pos_q, total, size);
						if (hdr_q[31:0] == 32'd12) begin
							out_ch.status <= vrrq_pkg::ST_DEQ_OK;
							out_ch.valid <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							cur_q <= wrap(cur_q, PW'(1), size);
							cnt_q <= 7'd0;
							state_q <= S_RD_PAY;
						end
					end
				end
				S_RD_PAY: begin
					// rdata_q holds payload byte cnt_q; cur_q is one ahead.
					if (!out_ch.valid || out_ch.ready) begin
						out_ch.status <= vrrq_pkg::ST_DEQ_OK;
						out_ch.out_byte <= rdata_q;
						out_ch.byte_valid <= 1'b1;
						out_ch.payload_len <= plen_q;
						out_ch.last <= cnt_q + 7'd1 == plen_q;
						out_ch.valid <= 1'b1;
						cnt_q <= cnt_q + 7'd1;
						cur_q <= wrap(cur_q, PW'(1), size);
						if (cnt_q + 7'd1 == plen_q) state_q <= S_IDLE;
					end else begin
						cur_q <= cur_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// A continuing byte that closes the message commits write_pos.
			if (state_q == S_IDLE && cmd_pop && cmd.kind == vrrq_pkg::CMD_ENQ_BYTE
				&& !rejected_q && owe_q == 7'd1)
				wr_pos_q <= wrap(fill_q, PW'(1), size);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) owe_q <= 7'd0;
		else if (clear) owe_q <= 7'd0;
		else if (cmd_pop && cmd.kind == vrrq_pkg::CMD_ENQ_OPEN)
			owe_q <= (cmd.msg_len == 7'd0) ? 7'd0 : cmd.msg_len - 7'd1;
		else if (cmd_pop && cmd.kind == vrrq_pkg::CMD_ENQ_BYTE && owe_q != 7'd0)
			owe_q <= owe_q - 7'd1;
	end
endmodule

// File: test/tb_vrrq_chan.sv
// Testbench types for the record ring queue: one request and one expected result.
// Depends on vrrq_pkg for the status codes.
package tb_vrrq_types;
	typedef struct {
		vrrq_pkg::status_t status;
		logic [7:0] out_byte;
		logic byte_valid;
		logic [63:0] flow;
		logic [6:0] plen;
		logic last;
	} result_t;

	typedef struct {
		logic req_type;
		logic [7:0] byte_value;
		logic [6:0] msg_len;
		logic [63:0] flow_id;
		logic [6:0] buf_limit;
	} request_t;
endpackage

// File: test/tb_top.sv
// Self-checking testbench for variable_record_ring_queue.
// Streams enqueue and dequeue requests, predicts every result transfer in a ring model
// and checks them in order. Depends on vrrq_pkg, vrrq_if.sv and tb_vrrq_chan.sv.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [12:0] cfg_wdata;

	vrrq_in_if in_ch();
	vrrq_out_if out_ch();

	variable_record_ring_queue u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	// Shadow of the queue.
	logic [7:0] shadow_ring [0:vrrq_pkg::RingBytes-1];
	int ring_len, rd_pos, wr_pos, fill_pos, items_left;
	bit rejected, empty_latch;

	tb_vrrq_types::request_t pending_reqs[$];
	tb_vrrq_types::result_t awaited[$];
	int send_idle, recv_idle;
	int errors, mismatches, results_seen, reqs_sent;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int ring_add(int p, int n);
		int q;
		q = p + n;
		while (q >= ring_len) q -= ring_len;
		return q;
	endfunction

	function automatic void queue_clear(int size_val);
		ring_len = size_val < vrrq_pkg::HdrBytes + vrrq_pkg::MaxMsgLen + 1
			? vrrq_pkg::HdrBytes + vrrq_pkg::MaxMsgLen + 1 : size_val;
		if (ring_len > vrrq_pkg::RingBytes) ring_len = vrrq_pkg::RingBytes;
		rd_pos = 0; wr_pos = 0; fill_pos = 0; items_left = 0;
		rejected = 0; empty_latch = 0;
	endfunction

	function automatic void push_result(vrrq_pkg::status_t st, logic [7:0] b, logic bv,
			logic [63:0] fl, logic [6:0] pl, logic lst);
		tb_vrrq_types::result_t r;
		r.status = st; r.out_byte = b; r.byte_valid = bv;
		r.flow = fl; r.plen = pl; r.last = lst;
		awaited.push_back(r);
	endfunction

	// Works out the results of one accepted request and updates the shadow queue.
	function automatic void predict_queue(tb_vrrq_types::request_t rq);
		int space_left, len, total, plen, pos;
		logic [63:0] fl;
		if (rq.req_type == 1'b0) begin
			if (items_left == 0) begin
				len = rq.msg_len;
				space_left = rd_pos > wr_pos ? rd_pos - wr_pos : rd_pos + ring_len - wr_pos;
				empty_latch = (rd_pos == wr_pos);
				items_left = (len == 0 ? 1 : len) - 1;
				if (len > vrrq_pkg::MaxMsgLen || space_left <= len + vrrq_pkg::HdrBytes) begin
					rejected = 1;
				end else begin
					rejected = 0;
					for (int i = 0; i < 4; i++)
						shadow_ring[ring_add(wr_pos, i)] =
							8'((len + vrrq_pkg::HdrBytes) >> (8 * i));
					for (int i = 0; i < 8; i++)
						shadow_ring[ring_add(wr_pos, 4 + i)] = rq.flow_id[8*i +: 8];
					fill_pos = ring_add(wr_pos, vrrq_pkg::HdrBytes);
					if (len != 0) begin
						shadow_ring[fill_pos] = rq.byte_value;
						fill_pos = ring_add(fill_pos, 1);
					end
					if (items_left == 0) wr_pos = fill_pos;
				end
			end else begin
				items_left--;
				if (!rejected) begin
					shadow_ring[fill_pos] = rq.byte_value;
					fill_pos = ring_add(fill_pos, 1);
					if (items_left == 0) wr_pos = fill_pos;
				end
			end
			push_result(rejected ? vrrq_pkg::ST_ENQ_FULL
				: (empty_latch ? vrrq_pkg::ST_ENQ_OK_EMPTY : vrrq_pkg::ST_ENQ_OK),
				8'd0, 1'b0, 64'd0, 7'd0, 1'b1);
		end else if (rd_pos == wr_pos) begin
			push_result(vrrq_pkg::ST_DEQ_EMPTY, 8'd0, 1'b0, 64'd0, 7'd0, 1'b1);
		end else begin
			total = 0;
			for (int i = 0; i < 4; i++)
				total |= int'(shadow_ring[ring_add(rd_pos, i)]) << (8 * i);
			for (int i = 0; i < 8; i++) fl[8*i +: 8] = shadow_ring[ring_add(rd_pos, 4 + i)];
			plen = total - vrrq_pkg::HdrBytes;
			if (plen > rq.buf_limit) begin
				push_result(vrrq_pkg::ST_DEQ_TOO_BIG, 8'd0, 1'b0, fl, 7'(plen), 1'b1);
			end else begin
				pos = ring_add(rd_pos, vrrq_pkg::HdrBytes);
				rd_pos = ring_add(rd_pos, total);
				if (plen == 0) push_result(vrrq_pkg::ST_DEQ_OK, 8'd0, 1'b0, fl, 7'd0, 1'b1);
				for (int i = 0; i < plen; i++) begin
					push_result(vrrq_pkg::ST_DEQ_OK, shadow_ring[pos], 1'b1, fl, 7'(plen),
						i + 1 == plen);
					pos = ring_add(pos, 1);
				end
			end
		end
	endfunction

	// Driver: presents queued requests, idling at the chosen rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_queue(pending_reqs.pop_front());
				reqs_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
					in_ch.valid <= 1'b1;
					in_ch.req_type <= pending_reqs[0].req_type;
					in_ch.byte_value <= pending_reqs[0].byte_value;
					in_ch.msg_len <= pending_reqs[0].msg_len;
					in_ch.flow_id <= pending_reqs[0].flow_id;
					in_ch.buf_limit <= pending_reqs[0].buf_limit;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: takes result transfers and compares with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		tb_vrrq_types::result_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (awaited.size() == 0) begin
					errors++;
					if (mismatches++ < 10) $display("Unexpected result, status %0d", out_ch.status);
				end else begin
					e = awaited.pop_front();
					if (out_ch.status !== e.status || out_ch.out_byte !== e.out_byte
							|| out_ch.byte_valid !== e.byte_valid || out_ch.out_flow_id !== e.flow
							|| out_ch.payload_len !== e.plen || out_ch.last !== e.last) begin
						errors++;
						if (mismatches++ < 10) begin
							$display("Mismatch: exp st %0d b %h bv %b f %h l %0d last %b",
								e.status, e.out_byte, e.byte_valid, e.flow, e.plen, e.last);
							$display("          got st %0d b %h bv %b f %h l %0d last %b",
								out_ch.status, out_ch.out_byte, out_ch.byte_valid,
								out_ch.out_flow_id, out_ch.payload_len, out_ch.last);
						end
					end
				end
			end
			out_ch.ready <= $urandom_range(99) >= recv_idle;
		end
	end

	function automatic tb_vrrq_types::request_t make_req(logic rt, int len, logic [63:0] fl,
			int lim);
		tb_vrrq_types::request_t r;
		r.req_type = rt;
		r.byte_value = 8'($urandom);
		r.msg_len = 7'(len);
		r.flow_id = fl;
		r.buf_limit = 7'(lim);
		return r;
	endfunction

	// Queues a whole message; the first item carries length and flow.
	task automatic add_message(int len, logic [63:0] fl);
		tb_vrrq_types::request_t r;
		r = make_req(1'b0, len, fl, 0);
		pending_reqs.push_back(r);
		for (int i = 1; i < len; i++) begin
			r = make_req(1'b0, $urandom_range(127), {$urandom, $urandom}, $urandom_range(127));
			pending_reqs.push_back(r);
		end
	endtask

	task automatic add_dequeue(int lim);
		pending_reqs.push_back(make_req(1'b1, $urandom_range(127), {$urandom, $urandom}, lim));
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while ((pending_reqs.size() > 0 || in_ch.valid || awaited.size() > 0)
				&& guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
	endtask

	task automatic write_size(int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 13'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		queue_clear(v);
	endtask

	// Random phase: mostly whole messages with random dequeues, some oversize and noise.
	task automatic random_traffic(int n);
		int k, len;
		k = 0;
		while (k < n) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					len = $urandom_range(3) == 0 ? 64 : $urandom_range(8);
					add_message(len, {$urandom, $urandom});
					k += len == 0 ? 1 : len;
				end
				4, 5, 6: begin
					add_dequeue($urandom_range(4) == 0 ? $urandom_range(127) : 64);
					k++;
				end
				7: begin
					add_message($urandom_range(65, 70), {$urandom, $urandom});
					k += 65;
				end
				default: begin
					// A dequeue in the middle of an open message.
					len = $urandom_range(2, 6);
					pending_reqs.push_back(make_req(1'b0, len, {$urandom, $urandom}, 0));
					add_dequeue(64);
					for (int i = 1; i < len; i++)
						pending_reqs.push_back(make_req(1'b0, 0, 64'd0, 0));
					k += len + 1;
				end
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.req_type = 1'b0;
		in_ch.byte_value = '0;
		in_ch.msg_len = '0;
		in_ch.flow_id = '0;
		in_ch.buf_limit = '0;
		out_ch.ready = 1'b0;
		errors = 0; mismatches = 0; results_seen = 0; reqs_sent = 0;
		send_idle = 22; recv_idle = 53;
		queue_clear(4096);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty dequeue, zero-length, extremes, too big, oversize, all-ones.
		add_dequeue(0);
		add_message(0, 64'd0);
		add_message(1, 64'hFFFF_FFFF_FFFF_FFFF);
		add_dequeue(64);
		add_dequeue(64);
		add_message(3, 64'h0123_4567_89AB_CDEF);
		add_dequeue(2);
		add_dequeue(127);
		add_message(127, 64'h5555_AAAA_5555_AAAA);
		add_dequeue(0);
		wait_drained();

		// Smallest ring: fill until full, then drain across the wrap.
		write_size(0);
		for (int i = 0; i < 6; i++) add_message(20, {$urandom, $urandom});
		for (int i = 0; i < 4; i++) add_dequeue(64);
		random_traffic(65);
		wait_drained();

		send_idle = 53; recv_idle = 22;
		write_size(8191);
		random_traffic(65);
		wait_drained();

		send_idle = 0; recv_idle = 0;
		write_size(200);
		random_traffic(65);
		wait_drained();

		$display("Requests accepted: %0d, result transfers checked: %0d.",
			reqs_sent, results_seen);
		$display("Ring sizes 4096, 77, 4096 and 200 under three idling patterns.");
		if (errors == 0 && awaited.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
